FILE: rtl/adc_sample_block_filter_macros.svh
// Assertion macros shared by the sample filter RTL.
`ifndef ADC_SAMPLE_BLOCK_FILTER_MACROS_SVH
`define ADC_SAMPLE_BLOCK_FILTER_MACROS_SVH

// same-cycle implication
`define ASBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/asbf_pkg.sv
// Package: shared constants and types of the ADC sample filter.
`default_nettype none
package asbf_pkg;

   localparam int WINDOW_LENGTH_DEF = 12;
   localparam int SAMPLE_BITS_DEF   = 12;
   localparam int MODE_BITS         = 3;

   localparam logic [MODE_BITS-1:0] MODE_MEDIAN   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_MEAN     = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_TRIMMED  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_WEIGHTED = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_MOVING   = 3'd4;

   // link from one sort cell to its right neighbor
   typedef struct packed {
      logic valid;
      logic below;   // inserted key sorts ahead of this cell's value
   } asbf_sort_link_type;

   // per-cycle commands to the sort chain
   typedef struct packed {
      logic clear;
      logic insert;
   } asbf_sort_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/asbf_store_cell.sv
// Store cell: one sample slot of the rotating sample ring.
`default_nettype none
module asbf_store_cell import asbf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   write_en,
   input  wire logic [SAMPLE_BITS-1:0] write_data,
   input  wire logic                   rotate,
   input  wire logic [SAMPLE_BITS-1:0] right_value,
   output logic      [SAMPLE_BITS-1:0] value
);

   logic [SAMPLE_BITS-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (write_en) begin
         value_in = write_data;
      end else if (rotate) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
`default_nettype wire

FILE: rtl/asbf_sort_cell.sv
// Sort cell: one slot of the insertion sorter, ascending left to right.
`default_nettype none
module asbf_sort_cell import asbf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire asbf_sort_ctl_type      ctl,
   input  wire logic [SAMPLE_BITS-1:0] key,
   input  wire asbf_sort_link_type     left_link,
   input  wire logic [SAMPLE_BITS-1:0] left_value,
   output asbf_sort_link_type          right_link,
   output logic      [SAMPLE_BITS-1:0] value
);

   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic                   below;

   assign below = valid_ff && (key < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (left_link.below) begin
            value_in = left_value;
            valid_in = 1'b1;
         end else if (left_link.valid && (below || !valid_ff)) begin
            value_in = key;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign right_link.valid = valid_ff;
   assign right_link.below = below;
   assign value            = value_ff;

endmodule
`default_nettype wire

FILE: rtl/asbf_divider.sv
// Divider: division by a constant through a registered reciprocal multiply.
`default_nettype none
module asbf_divider import asbf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int ACC_W       = 2 * SAMPLE_BITS_DEF,
   parameter int RCP_W       = 2 * SAMPLE_BITS_DEF + 8,
   parameter int SHIFT       = 2 * SAMPLE_BITS_DEF + 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [ACC_W-1:0]       dividend,
   input  wire logic [RCP_W-1:0]       recip,
   output logic                        done,
   output logic      [SAMPLE_BITS-1:0] quotient
);

   localparam int PROD_W = ACC_W + RCP_W;

   logic [ACC_W-1:0]  num_ff, num_in;
   logic [RCP_W-1:0]  rcp_ff, rcp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              mul_ff, mul_in;

   // quotient is prod >> SHIFT, exact for any dividend below 2**ACC_W
   always_comb begin
      num_in  = num_ff;
      rcp_in  = rcp_ff;
      prod_in = prod_ff;
      mul_in  = start;
      if (start) begin
         num_in = dividend;
         rcp_in = recip;
      end
      if (mul_ff) begin
         prod_in = PROD_W'(num_ff) * PROD_W'(rcp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 1'b0;
      end else begin
         mul_ff <= mul_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rcp_ff  <= rcp_in;
      prod_ff <= prod_in;
   end

   assign done     = mul_ff;
   assign quotient = prod_ff[SHIFT +: SAMPLE_BITS];

endmodule
`default_nettype wire

FILE: rtl/adc_sample_block_filter.sv
// Top level: ADC sample filter (median, mean, trimmed mean, weighted mean, moving average).
// One sample per req word. A sample that does not close a block leaves the filter idle and
// ready for the next one. A sample that closes a block, and every sample in moving-average
// mode, starts a pass in which the store ring rotates once through its WINDOW_LENGTH cells
// into the sum, weighted sum and insertion-sort chain; then come the load state, the divide
// state with the reciprocal multiplier (skipped for the median) and the finish state, which
// writes the rsp register. No new sample is taken until the pass is back in idle. Results
// leave through a register, so a new sample is taken while the last result waits; a result
// still waiting when the next pass ends holds the block until rsp takes it. The filter_mode
// register is written over the csr port between passes, ahead of a pending sample, and
// restarts the current block.
`default_nettype none
`include "adc_sample_block_filter_macros.svh"
module adc_sample_block_filter import asbf_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [TDATA_W-1:0]   req_tdata,    // [SAMPLE_BITS-1:0] sample
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [TDATA_W-1:0]   rsp_tdata,    // [SAMPLE_BITS-1:0] filtered
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [MODE_BITS-1:0] csr_data     // filter_mode
);

   localparam int W       = WINDOW_LENGTH;
   localparam int SB      = SAMPLE_BITS;
   localparam int IDX_W   = $clog2(W);
   localparam int WT_W    = $clog2(W + 1);
   localparam int ACC_W   = SB + $clog2(W * (W + 1) / 2 + 1);
   localparam int PROD_W  = SB + WT_W;
   localparam int MID     = (W - 1) / 2;
   localparam int SHIFT   = ACC_W + $clog2(W * (W + 1) / 2);
   localparam int RCP_W   = SHIFT + 1;
   localparam logic [RCP_W-1:0] RCP_MEAN     =
      RCP_W'(((64'd1 << SHIFT) + 64'(W) - 64'd1) / 64'(W));
   localparam logic [RCP_W-1:0] RCP_TRIMMED  =
      RCP_W'(((64'd1 << SHIFT) + 64'(W - 2) - 64'd1) / 64'(W - 2));
   localparam logic [RCP_W-1:0] RCP_WEIGHTED =
      RCP_W'(((64'd1 << SHIFT) + 64'(W * (W + 1) / 2) - 64'd1) / 64'(W * (W + 1) / 2));

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ACCUM  = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [IDX_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]       ring_ff, ring_in;
   logic [WT_W-1:0]        step_ff, step_in;
   logic [ACC_W-1:0]       sum_ff, sum_in;
   logic [ACC_W-1:0]       wsum_ff, wsum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]          rsp_data_ff, rsp_data_in;

   logic [SB-1:0]          sample;
   logic                   req_accept;
   logic                   csr_accept;
   logic                   rsp_free;
   logic                   store_write;
   logic [IDX_W-1:0]       store_idx;
   logic                   rotate;
   logic [SB-1:0]          head;
   logic [PROD_W-1:0]      product;
   asbf_sort_ctl_type      sort_ctl;
   logic                   div_start;
   logic [ACC_W-1:0]       div_dividend;
   logic [RCP_W-1:0]       div_recip;
   logic                   div_done;
   logic [SB-1:0]          div_quotient;

   logic [SB-1:0]          store_val [W];
   logic [SB-1:0]          sort_val  [W];
   asbf_sort_link_type     sort_link [W+1];

   assign sample     = req_tdata[SB-1:0];
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rotate     = (state_ff == ST_ACCUM);
   assign head       = store_val[0];
   assign product    = PROD_W'(head) * PROD_W'(step_ff);

   // store ring: each cell takes its right neighbor while rotating
   for (genvar k = 0; k < W; k++) begin : g_store
      asbf_store_cell #(.SAMPLE_BITS(SB)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .write_en    (store_write && (store_idx == IDX_W'(k))),
         .write_data  (sample),
         .rotate      (rotate),
         .right_value (store_val[(k + 1) % W]),
         .value       (store_val[k])
      );
   end

   // insertion sorter fed from the ring head
   assign sort_link[0] = '{valid: 1'b1, below: 1'b0};
   assign sort_ctl     = '{clear: req_accept, insert: rotate};

   for (genvar k = 0; k < W; k++) begin : g_sort
      asbf_sort_cell #(.SAMPLE_BITS(SB)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (sort_ctl),
         .key        (head),
         .left_link  (sort_link[k]),
         .left_value (sort_val[(k + W - 1) % W]),
         .right_link (sort_link[k+1]),
         .value      (sort_val[k])
      );
   end

   asbf_divider #(
      .SAMPLE_BITS (SB),
      .ACC_W       (ACC_W),
      .RCP_W       (RCP_W),
      .SHIFT       (SHIFT)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .recip    (div_recip),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      div_dividend = sum_ff;
      div_recip    = RCP_MEAN;
      case (mode_ff)
         MODE_TRIMMED: begin
            div_dividend = sum_ff - ACC_W'(sort_val[0]) - ACC_W'(sort_val[W-1]);
            div_recip    = RCP_TRIMMED;
         end
         MODE_WEIGHTED: begin
            div_dividend = wsum_ff;
            div_recip    = RCP_WEIGHTED;
         end
         default: begin
            div_dividend = sum_ff;
            div_recip    = RCP_MEAN;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      fill_in      = fill_ff;
      ring_in      = ring_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      wsum_in      = wsum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      store_write  = 1'b0;
      store_idx    = fill_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            sum_in  = '0;
            wsum_in = '0;
            step_in = WT_W'(1);
            if (req_accept) begin
               if (mode_ff == MODE_MOVING) begin
                  store_write = 1'b1;
                  store_idx   = ring_ff;
                  ring_in     = (ring_ff == IDX_W'(W - 1)) ? '0 : ring_ff + IDX_W'(1);
                  state_in    = ST_ACCUM;
               end else if (mode_ff inside {[MODE_MEDIAN:MODE_WEIGHTED]}) begin
                  store_write = 1'b1;
                  if (fill_ff == IDX_W'(W - 1)) begin
                     fill_in  = '0;
                     state_in = ST_ACCUM;
                  end else begin
                     fill_in = fill_ff + IDX_W'(1);
                  end
               end
            end
         end
         ST_ACCUM: begin
            sum_in  = sum_ff + ACC_W'(head);
            wsum_in = wsum_ff + ACC_W'(product);
            step_in = step_ff + WT_W'(1);
            if (step_ff == WT_W'(W)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (mode_ff == MODE_MEDIAN) begin
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (mode_ff == MODE_MEDIAN) ? sort_val[MID] : div_quotient;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_accept) begin
         mode_in = csr_data;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_MEDIAN;
         fill_ff      <= '0;
         ring_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         ring_ff      <= ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      sum_ff      <= sum_in;
      wsum_ff     <= wsum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   `ASBF_ASSERT_NEXT(a_moving_starts_pass, clock, reset,
      req_accept && (mode_ff == MODE_MOVING), state_ff == ST_ACCUM,
      "moving average pass not started")
   `ASBF_ASSERT_NEXT(a_partial_block_idle, clock, reset,
      req_accept && (mode_ff != MODE_MOVING) && (fill_ff != IDX_W'(W - 1)),
      state_ff == ST_IDLE, "partial block left idle")
   `ASBF_ASSERT_NEXT(a_finish_delivers, clock, reset,
      (state_ff == ST_FINISH) && rsp_free, rsp_tvalid && (state_ff == ST_IDLE),
      "result not delivered")
   `ASBF_ASSERT_NOW(a_done_in_divide, clock, reset,
      div_done, state_ff == ST_DIVIDE, "divider finished outside divide state")

endmodule
`default_nettype wire

FILE: bench/adc_sample_block_filter_checker.sv
// Checker: tracks the sample filter's state and compares every rsp word with its own prediction.
module adc_sample_block_filter_checker import asbf_pkg::*; #(
   parameter int TDATA_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [TDATA_W-1:0]   req_tdata,    // [11:0] sample
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [TDATA_W-1:0]   rsp_tdata,    // [11:0] filtered
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [MODE_BITS-1:0] csr_data,     // filter_mode
   output int                        outstanding,
   output int                        mismatches,
   output int                        results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W  = WINDOW_LENGTH_DEF;
   localparam int SB = SAMPLE_BITS_DEF;

   typedef logic [SB-1:0] sample_t;

   sample_t              window_mem [W];
   int unsigned          ring_slot;
   int unsigned          fill_level;
   logic [MODE_BITS-1:0] active_mode;
   sample_t              filtered_due [$];
   int                   err_count;
   int                   result_count;

   task automatic report_mismatch(input string what, input logic [TDATA_W-1:0] got,
                                  input logic [TDATA_W-1:0] want);
      $display("%0t ns mismatch: %s (got %h, want %h)", $time, what, got, want);
      err_count++;
   endtask

   // result of a complete block in the current block mode
   function automatic sample_t block_output();
      sample_t     ordered [W];
      sample_t     key;
      int          i;
      int          j;
      int unsigned acc;
      acc = 0;
      ordered = window_mem;
      for (i = 1; i < W; i++) begin
         key = ordered[i];
         j = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      case (active_mode)
         MODE_MEDIAN: begin
            return ordered[(W - 1) / 2];
         end
         MODE_MEAN: begin
            for (i = 0; i < W; i++) acc += window_mem[i];
            return sample_t'(acc / W);
         end
         MODE_TRIMMED: begin
            for (i = 1; i < W - 1; i++) acc += ordered[i];
            return sample_t'(acc / (W - 2));
         end
         default: begin
            for (i = 0; i < W; i++) acc += (i + 1) * window_mem[i];
            return sample_t'(acc / (W * (W + 1) / 2));
         end
      endcase
   endfunction

   task automatic absorb_sample(input sample_t smp);
      int          i;
      int unsigned acc;
      acc = 0;
      if (active_mode == MODE_MOVING) begin
         window_mem[ring_slot] = smp;
         ring_slot = (ring_slot + 1) % W;
         for (i = 0; i < W; i++) acc += window_mem[i];
         filtered_due.push_back(sample_t'(acc / W));
      end else if (active_mode < MODE_MOVING) begin
         window_mem[fill_level] = smp;
         fill_level++;
         if (fill_level == W) begin
            fill_level = 0;
            filtered_due.push_back(block_output());
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (window_mem[i]) window_mem[i] = '0;
         ring_slot = 0;
         fill_level = 0;
         active_mode = MODE_MEDIAN;
         filtered_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            active_mode = csr_data;
            fill_level = 0;
         end
         if (req_tvalid && req_tready) absorb_sample(req_tdata[SB-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_due.size() == 0) begin
               report_mismatch("rsp word with nothing expected", rsp_tdata, '0);
            end else begin
               sample_t want;
               want = filtered_due.pop_front();
               result_count++;
               if (rsp_tdata[SB-1:0] !== want)
                  report_mismatch("filtered value", rsp_tdata, TDATA_W'(want));
               if (rsp_tdata[TDATA_W-1:SB] !== '0)
                  report_mismatch("nonzero pad bits", rsp_tdata, TDATA_W'(want));
            end
         end
      end
      outstanding     <= filtered_due.size();
      mismatches      <= err_count;
      results_checked <= result_count;
   end

endmodule

FILE: bench/tb_adc_sample_block_filter.sv
// Testbench top: drives samples, mode writes and rsp back-pressure into the ADC sample filter.
module tb_adc_sample_block_filter;
   timeunit 1ns;
   timeprecision 1ps;
   import asbf_pkg::*;

   localparam int W              = WINDOW_LENGTH_DEF;
   localparam int SB             = SAMPLE_BITS_DEF;
   localparam int TDATA_W        = ((SB + 7) / 8) * 8;
   localparam int ITEMS          = 550;
   localparam int DRAIN_CYCLES   = W + SB + 16;
   localparam int SQUEEZE_CYCLES = 300;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata  = '0;      // [11:0] sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;            // [11:0] filtered
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [MODE_BITS-1:0] csr_data   = MODE_MEDIAN;
   logic                 squeeze    = 1'b0;

   int                   outstanding;
   int                   mismatches;
   int                   results_checked;

   logic [MODE_BITS-1:0] cur_mode;
   int                   samples_sent;
   int                   ignored_sent;
   int                   mode_writes;
   int                   mode_phases [8];
   int                   brisk_left;

   logic [SB-1:0] corner_samples [W] = '{
      12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'h800, 12'h7FF,
      12'h001, 12'hFFE, 12'hAAA, 12'h555, 12'hFFF, 12'h000
   };

   always #5 clock = ~clock;

   adc_sample_block_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   adc_sample_block_filter_checker #(.TDATA_W(TDATA_W)) watcher (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .outstanding     (outstanding),
      .mismatches      (mismatches),
      .results_checked (results_checked)
   );

   // mostly short gaps, a few long ones, now and then a run with none
   function automatic int pick_gap();
      int r;
      if (brisk_left > 0) begin
         brisk_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) brisk_left = $urandom_range(20, 60);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic logic [SB-1:0] adc_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return SB'($urandom_range(0, (1 << SB) - 1));
      if (r < 70) return '0;
      if (r < 80) return '1;
      return SB'($urandom_range(2000, 2100));
   endfunction

   task automatic send_sample(input logic [SB-1:0] smp, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(smp);
      do @(posedge clock); while (!req_tready);
      if (cur_mode > MODE_MOVING) ignored_sent++;
      else samples_sent++;
   endtask

   task automatic feed(input int count);
      repeat (count) send_sample(adc_value(), pick_gap());
   endtask

   // wait until every result is in and the block has gone quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_BITS-1:0] m);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = m;
      mode_writes++;
      mode_phases[m]++;
   endtask

   // rsp side: random stalls, plus one long hold-off when squeeze is raised
   initial begin : rsp_side
      int  r;
      int  hold_left;
      int  calm_left;
      bit  squeeze_done;
      hold_left = 0;
      calm_left = 0;
      squeeze_done = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 20) hold_left = $urandom_range(1, 3);
               else if (r < 23) hold_left = $urandom_range(15, 60);
               else if (r < 25) calm_left = $urandom_range(30, 120);
            end
         end
      end
   end

   initial begin : stimulus
      int                   phase;
      int                   count;
      int                   r;
      logic [MODE_BITS-1:0] m;
      samples_sent = 0;
      ignored_sent = 0;
      mode_writes = 0;
      brisk_left = 0;
      foreach (mode_phases[i]) mode_phases[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      cur_mode = MODE_MEDIAN;
      mode_phases[MODE_MEDIAN]++;

      // median over one block of corner values, straight from reset
      foreach (corner_samples[i]) send_sample(corner_samples[i], pick_gap());
      // ring starts on top of the block samples
      write_mode(MODE_MOVING);
      send_sample('1, 0);
      send_sample('1, 1);
      send_sample('0, 0);
      send_sample('1, 2);
      // partial block, then a mode write restarts it; unused mode drops samples
      write_mode(MODE_WEIGHTED);
      repeat (5) send_sample(adc_value(), pick_gap());
      write_mode(MODE_MOVING + MODE_BITS'(3));
      send_sample('1, 0);
      send_sample('0, 1);

      // back-pressure: rsp held off while samples keep coming
      write_mode(MODE_MOVING);
      squeeze <= 1'b1;
      repeat (40) send_sample(adc_value(), 0);

      phase = 0;
      while (samples_sent < ITEMS) begin
         r = $urandom_range(0, 99);
         if (phase < 4) m = MODE_MEAN + MODE_BITS'(phase);
         else if (r < 12) m = MODE_MOVING + MODE_BITS'($urandom_range(1, 3));
         else m = MODE_BITS'($urandom_range(MODE_MEDIAN, MODE_MOVING));
         write_mode(m);
         if (m == MODE_MOVING) begin
            count = $urandom_range(5, 40);
         end else if (m > MODE_MOVING) begin
            count = $urandom_range(1, 6);
         end else begin
            count = W * $urandom_range(1, 4);
            if ($urandom_range(0, 99) < 30) count += $urandom_range(1, W - 1);
         end
         feed(count);
         phase++;
      end
      drain();

      $display("run: %0d samples filtered, %0d dropped in unused modes, %0d mode writes",
               samples_sent, ignored_sent, mode_writes);
      $display("run: %0d results checked; phases median %0d mean %0d trimmed %0d weighted %0d moving %0d unused %0d",
               results_checked, mode_phases[MODE_MEDIAN], mode_phases[MODE_MEAN],
               mode_phases[MODE_TRIMMED], mode_phases[MODE_WEIGHTED], mode_phases[MODE_MOVING],
               mode_phases[5] + mode_phases[6] + mode_phases[7]);
      if (mismatches == 0) begin
         $display("tb_adc_sample_block_filter: done, clean");
      end else begin
         $display("tb_adc_sample_block_filter: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("watchdog expired");
      $display("tb_adc_sample_block_filter: done, errors");
      $finish;
   end

endmodule
